>>> hw/rtl/scpc_pkg.sv
`timescale 1ns / 1ps

package scpc_pkg;

	localparam int BASE_W  = 10;
	localparam int LEN_W   = 16;
	localparam int COUNT_W = 64;
	localparam int FEW_W   = 16;
	localparam int FIN_W   = 10;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	// Register indexes, taken from paddr[2].
	localparam logic [0:0] REG_JUMP_BASE    = 1'b0;
	localparam logic [0:0] REG_STAIR_LENGTH = 1'b1;

	localparam logic [BASE_W-1:0] BASE_RESET = 10'd2;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 16'd900;

	localparam logic [LEN_W-1:0] STEP_MAX = 16'hFFFF;
	localparam logic [FEW_W-1:0] FEW_MAX  = 16'hFFFF;

	typedef struct packed {
		logic step_blocked;
		logic new_staircase;
	} step_t;

	typedef struct packed {
		logic [COUNT_W-1:0] way_count;
		logic               reachable;
		logic [FEW_W-1:0]   fewest_jumps;
		logic [FIN_W-1:0]   final_jump;
		logic               final_step;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic issue;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic loop_more;
	} sts_t;

endpackage

>>> hw/rtl/scpc_stream_if.sv
`timescale 1ns / 1ps

interface scpc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/scpc_cfg.sv
`timescale 1ns / 1ps

module scpc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [scpc_pkg::PADDR_W-1:0]       paddr,
	input  logic [scpc_pkg::PDATA_W-1:0]       pwdata,
	output logic [scpc_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	output logic [scpc_pkg::BASE_W-1:0]        jump_base,
	output logic [scpc_pkg::LEN_W-1:0]         stair_length
);

	logic [scpc_pkg::BASE_W-1:0] base_q;
	logic [scpc_pkg::LEN_W-1:0]  len_q;
	logic [0:0]                  reg_idx;
	logic                        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= scpc_pkg::BASE_RESET;
			len_q  <= scpc_pkg::LEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				scpc_pkg::REG_JUMP_BASE: begin
					base_q <= pwdata[scpc_pkg::BASE_W-1:0];
				end
				scpc_pkg::REG_STAIR_LENGTH: begin
					len_q <= pwdata[scpc_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			scpc_pkg::REG_JUMP_BASE:    prdata = scpc_pkg::PDATA_W'(base_q);
			scpc_pkg::REG_STAIR_LENGTH: prdata = scpc_pkg::PDATA_W'(len_q);
			default:                    prdata = '0;
		endcase
	end

	assign jump_base    = base_q;
	assign stair_length = len_q;

endmodule

>>> hw/rtl/scpc_ctrl.sv
`timescale 1ns / 1ps

module scpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  scpc_pkg::sts_t sts,
	output scpc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q, out_vld_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		out_vld_d = out_vld_q;
		if (out_vld_q && out_ready) begin
			out_vld_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.loop_more) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Wait for the result register to be free.
				if (!out_vld_q || out_ready) begin
					cmd.finish = 1'b1;
					out_vld_d  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= out_vld_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;

endmodule

>>> hw/rtl/scpc_datapath.sv
`timescale 1ns / 1ps

module scpc_datapath #(
	parameter int WINDOW = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scpc_pkg::cmd_t               cmd,
	output scpc_pkg::sts_t               sts,
	input  scpc_pkg::step_t              in_item,
	input  logic [scpc_pkg::BASE_W-1:0]  jump_base,
	input  logic [scpc_pkg::LEN_W-1:0]   stair_length,
	output scpc_pkg::result_t            result
);

	localparam int AW = $clog2(WINDOW);
	localparam int PW = AW + scpc_pkg::BASE_W;
	localparam logic [AW:0]   WIN_EXT  = (AW+1)'(WINDOW);
	localparam logic [AW-1:0] SLOT_TOP = AW'(WINDOW - 1);
	localparam logic [31:0]   WIN32    = 32'(WINDOW);

	typedef struct packed {
		logic                         reach;
		logic [scpc_pkg::FEW_W-1:0]   best;
		logic [scpc_pkg::COUNT_W-1:0] way;
	} entry_t;

	entry_t ring_q [WINDOW];
	entry_t rd_s1;

	logic [scpc_pkg::LEN_W-1:0] step_q;
	logic [AW-1:0]              slot_q;
	logic                       blk_q;
	logic                       first_q;
	logic [PW-1:0]              pw_q;
	logic [PW+scpc_pkg::BASE_W-1:0] pw_prod;

	logic [AW-1:0] s_cur;
	logic          direct_cur;
	logic          look_cur;
	logic [AW:0]   back_diff;
	logic [AW-1:0] back_addr;

	logic          vld_s1;
	logic [AW-1:0] s_s1;
	logic          direct_s1;
	logic          look_s1;

	logic [scpc_pkg::COUNT_W-1:0] acc_count_q, acc_count_d;
	logic                         acc_reach_q, acc_reach_d;
	logic [scpc_pkg::FEW_W-1:0]   acc_best_q, acc_best_d;
	logic [AW-1:0]                acc_fin_q, acc_fin_d;
	logic [scpc_pkg::FEW_W-1:0]   cand;

	scpc_pkg::result_t out_q;

	// Jump loop: the current power is used while it is within the stair length and the
	// window; a base below two allows only the first jump.
	assign sts.loop_more = !blk_q
		&& (32'(pw_q) <= 32'(stair_length))
		&& (32'(pw_q) < WIN32)
		&& (first_q || (jump_base[scpc_pkg::BASE_W-1:1] != '0));

	assign s_cur      = pw_q[AW-1:0];
	assign direct_cur = (32'(s_cur) == 32'(step_q));
	assign look_cur   = (32'(step_q) > 32'(s_cur));

	assign back_diff = {1'b0, slot_q} - {1'b0, s_cur};
	assign back_addr = back_diff[AW] ? AW'(back_diff + WIN_EXT) : back_diff[AW-1:0];

	assign pw_prod = {{scpc_pkg::BASE_W{1'b0}}, pw_q} * {{PW{1'b0}}, jump_base};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			slot_q  <= '0;
			blk_q   <= 1'b0;
			first_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				blk_q   <= in_item.step_blocked;
				first_q <= 1'b1;
				if (in_item.new_staircase || step_q == scpc_pkg::STEP_MAX) begin
					step_q <= scpc_pkg::LEN_W'(1);
					slot_q <= AW'(1);
				end else begin
					step_q <= step_q + 1'b1;
					slot_q <= (slot_q == SLOT_TOP) ? '0 : slot_q + 1'b1;
				end
			end else if (cmd.issue) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pw_q <= PW'(1);
		end else if (cmd.issue) begin
			pw_q <= pw_prod[PW-1:0];
		end
		if (cmd.issue) begin
			s_s1      <= s_cur;
			direct_s1 <= direct_cur;
			look_s1   <= look_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1 <= ring_q[back_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ring_q[slot_q] <= '{reach: acc_reach_q, best: acc_best_q, way: acc_count_q};
		end
	end

	assign cand = (rd_s1.best == scpc_pkg::FEW_MAX) ? scpc_pkg::FEW_MAX : rd_s1.best + 1'b1;

	always_comb begin
		acc_count_d = acc_count_q;
		acc_reach_d = acc_reach_q;
		acc_best_d  = acc_best_q;
		acc_fin_d   = acc_fin_q;
		if (cmd.start) begin
			acc_count_d = '0;
			acc_reach_d = 1'b0;
			acc_best_d  = '0;
			acc_fin_d   = '0;
		end else if (vld_s1) begin
			if (direct_s1) begin
				// A direct landing always takes the shortest route.
				acc_count_d = acc_count_q + 1'b1;
				acc_reach_d = 1'b1;
				acc_best_d  = scpc_pkg::FEW_W'(1);
				acc_fin_d   = s_s1;
			end else if (look_s1 && rd_s1.reach) begin
				acc_count_d = acc_count_q + rd_s1.way;
				acc_reach_d = 1'b1;
				if (acc_best_q == '0
					|| (cand <= acc_best_q && acc_best_q != scpc_pkg::FEW_W'(1))) begin
					acc_best_d = cand;
					acc_fin_d  = s_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_count_q <= '0;
			acc_reach_q <= 1'b0;
			acc_best_q  <= '0;
			acc_fin_q   <= '0;
		end else begin
			acc_count_q <= acc_count_d;
			acc_reach_q <= acc_reach_d;
			acc_best_q  <= acc_best_d;
			acc_fin_q   <= acc_fin_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.way_count    <= acc_count_q;
			out_q.reachable    <= acc_reach_q;
			out_q.fewest_jumps <= acc_best_q;
			out_q.final_jump   <= scpc_pkg::FIN_W'(acc_fin_q);
			out_q.final_step   <= (step_q == stair_length);
		end
	end

	assign result = out_q;

	// An unreachable partial result carries no count and no route length.
	a_unreach_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_reach_q |-> (acc_count_q == '0 && acc_best_q == '0))
		else $error("count or route length without reachability");

	// A look-back never reads the entry of the step being computed.
	a_back_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && look_cur) |-> (back_addr != slot_q))
		else $error("look-back addresses the current slot");

endmodule

>>> hw/rtl/staircase_path_count_dp.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                              Handshake
// steps     in         step_blocked, new_staircase                          valid/ready
// results   out        way_count, reachable, fewest_jumps, final_jump,      valid/ready
//                      final_step
// APB       in/out     jump_base (0x0), stair_length (0x4)                  psel/penable
//
// Each step makes one look-back read per allowed jump (the powers of jump_base up to
// stair_length and below WINDOW) through the single read port of the history ring;
// a blocked step makes none. Reset needs no clearing pass, since a look-back only
// reaches steps written since the staircase began. A waiting result sits in the
// output register while the next step is accepted and computed.

module staircase_path_count_dp #(
	parameter int WINDOW = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	scpc_stream_if.sink                   steps,
	scpc_stream_if.source                 results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scpc_pkg::PADDR_W-1:0]  paddr,
	input  logic [scpc_pkg::PDATA_W-1:0]  pwdata,
	output logic [scpc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [scpc_pkg::BASE_W-1:0] jump_base;
	logic [scpc_pkg::LEN_W-1:0]  stair_length;
	scpc_pkg::cmd_t              cmd;
	scpc_pkg::sts_t              sts;
	scpc_pkg::step_t             in_item;
	scpc_pkg::result_t           result;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	scpc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.jump_base    (jump_base),
		.stair_length (stair_length)
	);

	// The controller accepts a transaction, steps the jump loop and hands the
	// finished result to the output register once it is free.
	scpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (steps.valid),
		.in_ready  (steps.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	assign in_item = steps.payload;

	// The datapath holds the step counter, the history ring of counts and route
	// lengths, the look-back stage and the result register.
	scpc_datapath #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_item      (in_item),
		.jump_base    (jump_base),
		.stair_length (stair_length),
		.result       (result)
	);

	assign results.payload = result;

	// Steps are taken one at a time: after a transaction the input stays closed
	// until its result has been produced.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(steps.valid && steps.ready) |=> !steps.ready)
		else $error("second transaction accepted while a step is in progress");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int WINDOW = 1024;
	// Slowest correct run: about 525 steps, each possibly followed by sender idling,
	// random holds on the receiver, one long receiver hold and the drains around
	// 28 register writes. The limit is set above that run.
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [1:0] {ROW_STEP, ROW_BASE, ROW_LEN} row_kind_e;

	typedef struct {
		row_kind_e           kind;
		bit                  blocked;
		bit                  fresh;
		logic [15:0]         value;
		bit                  typed;
		scpc_pkg::result_t   want;
	} plan_row_t;

	localparam scpc_pkg::result_t NO_ROUTE = '0;
	localparam scpc_pkg::result_t FIRST_STEP = '{way_count: 64'd1, reachable: 1'b1,
		fewest_jumps: 16'd1, final_jump: 10'd1, final_step: 1'b0};
	localparam scpc_pkg::result_t FIRST_AND_LAST = '{way_count: 64'd1, reachable: 1'b1,
		fewest_jumps: 16'd1, final_jump: 10'd1, final_step: 1'b1};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [scpc_pkg::PADDR_W-1:0] paddr;
	logic [scpc_pkg::PDATA_W-1:0] pwdata;
	logic [scpc_pkg::PDATA_W-1:0] prdata;
	logic pready;

	scpc_stream_if #(.payload_t(scpc_pkg::step_t)) step_chan ();
	scpc_stream_if #(.payload_t(scpc_pkg::result_t)) result_chan ();

	staircase_path_count_dp #(.WINDOW(WINDOW)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.steps   (step_chan),
		.results (result_chan),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Shadow of the block: its registers and the history of recent steps.
	logic [scpc_pkg::BASE_W-1:0] base_cfg = scpc_pkg::BASE_RESET;
	logic [scpc_pkg::LEN_W-1:0] len_cfg = scpc_pkg::LEN_RESET;
	bit [scpc_pkg::COUNT_W-1:0] way_hist [WINDOW];
	bit reach_hist [WINDOW];
	bit [scpc_pkg::FEW_W-1:0] few_hist [WINDOW];
	int unsigned step_num = 0;

	// Results that the block still owes, oldest first.
	scpc_pkg::result_t pending_results[$];

	// Directed stimulus table.
	plan_row_t plan[$];

	int unsigned mismatches = 0;
	int unsigned steps_sent = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	function automatic void add_row(plan_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic void owe_result(scpc_pkg::result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Count of routes, shortest route and its last jump for the next step in order.
	// The shadow history is updated exactly as the block stores it.
	function automatic scpc_pkg::result_t predict_step(bit blocked, bit fresh);
		scpc_pkg::result_t r;
		bit [scpc_pkg::COUNT_W-1:0] ways;
		bit hit;
		int unsigned best;
		int unsigned last_jump;
		int unsigned slot;
		int unsigned hop;
		int unsigned back;
		int unsigned cand;
		longint unsigned pw;
		ways = '0;
		hit = 1'b0;
		best = 0;
		last_jump = 0;
		pw = 1;
		// A fresh staircase, or a step counter about to run past its top, forgets
		// everything seen so far.
		if (fresh || step_num >= scpc_pkg::STEP_MAX) begin
			foreach (way_hist[i]) begin
				way_hist[i] = '0;
				reach_hist[i] = 1'b0;
				few_hist[i] = '0;
			end
			step_num = 0;
		end
		step_num++;
		slot = step_num % WINDOW;
		if (!blocked) begin
			while (pw <= len_cfg && pw < WINDOW) begin
				hop = 32'(pw);
				// Landing straight from the ground always wins the tie-break.
				if (hop == step_num) begin
					ways += 64'd1;
					hit = 1'b1;
					best = 1;
					last_jump = hop;
				end
				// Steps before step 1 do not exist, so only look back inside the staircase.
				if (step_num > hop) begin
					back = (step_num - hop) % WINDOW;
					if (reach_hist[back]) begin
						cand = few_hist[back] + 1;
						if (cand > scpc_pkg::FEW_MAX)
							cand = scpc_pkg::FEW_MAX;
						ways += way_hist[back];
						hit = 1'b1;
						// Jumps are visited from small to large, so "<=" lets the larger
						// jump take an equal-length tie.
						if (best == 0 || (cand <= best && best != 1)) begin
							best = cand;
							last_jump = hop;
						end
					end
				end
				// A base of zero or one only ever allows the jump of one.
				if (base_cfg < 2)
					break;
				pw *= base_cfg;
			end
		end
		if (!hit) begin
			ways = '0;
			best = 0;
			last_jump = 0;
		end
		way_hist[slot] = ways;
		reach_hist[slot] = hit;
		few_hist[slot] = best[scpc_pkg::FEW_W-1:0];
		r.way_count = ways;
		r.reachable = hit;
		r.fewest_jumps = best[scpc_pkg::FEW_W-1:0];
		r.final_jump = last_jump[scpc_pkg::FIN_W-1:0];
		r.final_step = (step_num == len_cfg);
		return r;
	endfunction

	function automatic void note_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $time, msg);
	endfunction

	function automatic void check_result(scpc_pkg::result_t got);
		scpc_pkg::result_t want;
		if (pending_results.size() == 0) begin
			note_error($sformatf("result with nothing outstanding: ways=%0d reach=%0d",
				got.way_count, got.reachable));
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.way_count !== want.way_count || got.reachable !== want.reachable ||
				got.fewest_jumps !== want.fewest_jumps || got.final_jump !== want.final_jump ||
				got.final_step !== want.final_step)
			note_error($sformatf({"result %0d: expected ways=%0d reach=%0d jumps=%0d last=%0d ",
				"final=%0d, got ways=%0d reach=%0d jumps=%0d last=%0d final=%0d"},
				results_checked, want.way_count, want.reachable, want.fewest_jumps,
				want.final_jump, want.final_step, got.way_count, got.reachable,
				got.fewest_jumps, got.final_jump, got.final_step));
	endfunction

	// Offers one step until the block takes it, then records what it must return.
	// A typed expectation replaces the prediction, but the shadow still advances.
	task automatic offer_step(bit blocked, bit fresh, bit typed, scpc_pkg::result_t want);
		scpc_pkg::step_t item;
		scpc_pkg::result_t predicted;
		item.step_blocked = blocked;
		item.new_staircase = fresh;
		step_chan.valid <= 1'b1;
		step_chan.payload <= item;
		do
			@(posedge clk);
		while (!step_chan.ready);
		predicted = predict_step(blocked, fresh);
		owe_result(typed ? want : predicted);
		steps_sent++;
		if (!quiet && $urandom_range(99) < 11) begin
			step_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed result has been taken.
	task automatic wait_drained();
		step_chan.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write followed by a read of the same register.
	task automatic write_reg(logic [0:0] idx, logic [scpc_pkg::PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		reg_writes++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== value)
			note_error($sformatf("register %0d read back %0h, wrote %0h", idx, prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_base(logic [scpc_pkg::BASE_W-1:0] value);
		wait_drained();
		write_reg(scpc_pkg::REG_JUMP_BASE, scpc_pkg::PDATA_W'(value));
		base_cfg = value;
	endtask

	task automatic set_length(logic [scpc_pkg::LEN_W-1:0] value);
		wait_drained();
		write_reg(scpc_pkg::REG_STAIR_LENGTH, scpc_pkg::PDATA_W'(value));
		len_cfg = value;
	endtask

	function automatic plan_row_t step_row(bit blocked, bit fresh);
		return '{kind: ROW_STEP, blocked: blocked, fresh: fresh, value: '0, typed: 1'b0,
			want: NO_ROUTE};
	endfunction

	function automatic plan_row_t typed_row(bit blocked, bit fresh, scpc_pkg::result_t want);
		return '{kind: ROW_STEP, blocked: blocked, fresh: fresh, value: '0, typed: 1'b1,
			want: want};
	endfunction

	function automatic plan_row_t cfg_row(row_kind_e kind, logic [15:0] value);
		return '{kind: kind, blocked: 1'b0, fresh: 1'b0, value: value, typed: 1'b0,
			want: NO_ROUTE};
	endfunction

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: checks every transaction and drives ready. It idles at random,
	// never while quiet is set, and once holds ready low for a long stretch so that
	// the block backs up and stalls its step input.
	initial begin
		result_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_chan.valid && result_chan.ready)
				check_result(result_chan.payload);
			if (hold_left > 0) begin
				hold_left--;
				result_chan.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				result_chan.ready <= 1'b0;
			end else begin
				result_chan.ready <= arst_n && (quiet || $urandom_range(99) >= 11);
			end
		end
	end

	initial begin
		plan_row_t row;
		int block_pct;
		logic [scpc_pkg::BASE_W-1:0] base_pick;
		logic [scpc_pkg::LEN_W-1:0] len_pick;

		arst_n <= 1'b0;
		step_chan.valid <= 1'b0;
		step_chan.payload <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset settings: base 2, length 900.
		// The first step after reset needs no new_staircase and lands directly.
		add_row(typed_row(1'b0, 1'b0, FIRST_STEP));
		add_row(step_row(1'b0, 1'b0));
		// Step 3 is reached in two jumps either way; the jump of 2 must win the tie.
		add_row(step_row(1'b0, 1'b0));
		add_row(typed_row(1'b1, 1'b0, NO_ROUTE));
		// Step 5 looks back into the blocked step 4.
		add_row(step_row(1'b0, 1'b0));
		add_row(step_row(1'b0, 1'b0));
		// A fresh staircase whose first step is blocked.
		add_row(typed_row(1'b1, 1'b1, NO_ROUTE));
		add_row(step_row(1'b0, 1'b0));
		add_row(typed_row(1'b0, 1'b1, FIRST_STEP));
		// Shortest staircase and the widest base: step 1 is also the final step,
		// step 2 lies beyond the length.
		add_row(cfg_row(ROW_LEN, 16'd1));
		add_row(cfg_row(ROW_BASE, 16'd1023));
		add_row(typed_row(1'b0, 1'b1, FIRST_AND_LAST));
		add_row(step_row(1'b0, 1'b0));
		// Bases below two allow only the jump of one; the history carries over.
		add_row(cfg_row(ROW_BASE, 16'd0));
		add_row(cfg_row(ROW_LEN, 16'd65535));
		add_row(typed_row(1'b0, 1'b1, FIRST_STEP));
		add_row(step_row(1'b0, 1'b0));
		add_row(cfg_row(ROW_BASE, 16'd1));
		add_row(step_row(1'b0, 1'b0));
		// A zero length allows no jump at all, so nothing is reachable.
		add_row(cfg_row(ROW_LEN, 16'd0));
		add_row(typed_row(1'b0, 1'b1, NO_ROUTE));
		add_row(typed_row(1'b0, 1'b0, NO_ROUTE));
		// Length 8 with base 2: jumps 1, 2, 4 and 8; step 8 is final, step 9 beyond.
		add_row(cfg_row(ROW_BASE, 16'd2));
		add_row(cfg_row(ROW_LEN, 16'd8));
		add_row(step_row(1'b0, 1'b1));
		for (int i = 2; i <= 9; i++)
			add_row(step_row(i == 6, 1'b0));

		foreach (plan[i]) begin
			row = plan[i];
			case (row.kind)
				ROW_BASE: begin
					set_base(row.value[scpc_pkg::BASE_W-1:0]);
				end
				ROW_LEN: begin
					set_length(row.value);
				end
				default: begin
					offer_step(row.blocked, row.fresh, row.typed, row.want);
				end
			endcase
		end

		// Random part: ten segments of fifty steps, each opening a fresh staircase under its own settings.
		for (int seg = 0; seg < 10; seg++) begin
			case ($urandom_range(0, 4))
				0: base_pick = 10'd2;
				1: base_pick = 10'd3;
				2: base_pick = 10'd1023;
				3: base_pick = scpc_pkg::BASE_W'($urandom_range(0, 1));
				default: base_pick = scpc_pkg::BASE_W'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(0, 4))
				0: len_pick = scpc_pkg::LEN_W'($urandom_range(1, 40));
				1: len_pick = 16'd65535;
				2: len_pick = scpc_pkg::LEN_W'($urandom_range(0, 1));
				default: len_pick = scpc_pkg::LEN_W'($urandom_range(0, 65535));
			endcase
			set_base(base_pick);
			set_length(len_pick);
			// One staircase runs with no idling on either side.
			quiet = (seg == 8);
			block_pct = $urandom_range(0, 30);
			// The receiver stops for a long stretch while steps keep coming.
			if (seg == 3)
				hold_request = 1'b1;
			offer_step($urandom_range(99) < block_pct, 1'b1, 1'b0, NO_ROUTE);
			for (int k = 1; k < 50; k++) begin
				// Halfway through one staircase, the sender waits for every result.
				if (seg == 6 && k == 25)
					wait_drained();
				offer_step($urandom_range(99) < block_pct, $urandom_range(99) < 3, 1'b0,
					NO_ROUTE);
			end
		end
		wait_drained();

		$display("Run covered %0d steps and %0d checked results over %0d register writes,",
			steps_sent, results_checked, reg_writes);
		$display("with blocked steps, fresh staircases, extreme settings and a long stall.");
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/scpc_pkg.sv
hw/rtl/scpc_stream_if.sv
hw/rtl/scpc_cfg.sv
hw/rtl/scpc_ctrl.sv
hw/rtl/scpc_datapath.sv
hw/rtl/staircase_path_count_dp.sv
sim/testbench.sv
